@@ rtl/core/clpt_pkg.sv @@
// ----------------------------------------------------------------------------
// clpt_pkg: shared types and constants of the channel low pulse timer
// Entry layout of the per-channel state memory, pipeline control groups and
// the fixed constants of the duration rounding.
// ----------------------------------------------------------------------------
package clpt_pkg;

	localparam logic [7:0]  LEVEL_RESET   = 8'hFF;
	localparam logic [7:0]  LEVEL_LOW     = 8'h00;
	localparam logic [7:0]  LEVEL_HIGH    = 8'h01;
	localparam logic [7:0]  SECONDS_MAX   = 8'hFF;
	localparam int unsigned ROUND_BIAS    = 200;
	localparam int unsigned MS_PER_SECOND = 1000;

	// Rounded sums at or above this value give more than SECONDS_MAX seconds.
	localparam int unsigned SAT_SUM     = (256 * MS_PER_SECOND);
	localparam int unsigned SUM_W       = $clog2(SAT_SUM);
	localparam int unsigned RECIP_SHIFT = 28;
	localparam int unsigned RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND);

	typedef struct packed {
		logic [7:0]  level;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic        timed;
		logic [31:0] elapsed;
	} upd_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

@@ rtl/core/clpt_ram.sv @@
// ----------------------------------------------------------------------------
// clpt_ram: generic simple dual port RAM
// One write port and one read port with a registered read. A read at the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module clpt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 48,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/clpt_slot.sv @@
// ----------------------------------------------------------------------------
// clpt_slot: per-channel read-modify-write stage
// Takes the entry read for the sample in stage one, forwards the most recent
// write when it hit the same slot, and forms the new entry and elapsed time.
// ----------------------------------------------------------------------------
module clpt_slot #(
	parameter int SLOT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clpt_pkg::entry_t  rd_entry,
	input  logic [SLOT_W-1:0] slot_s1,
	input  logic              in_range_s1,
	input  logic [7:0]        level_s1,
	input  logic [31:0]       now_s1,
	input  logic              commit,
	output logic              changed,
	output clpt_pkg::entry_t  wr_entry,
	output clpt_pkg::upd_t    upd
);

	import clpt_pkg::*;

	logic              fwd_valid_q;
	logic [SLOT_W-1:0] fwd_slot_q;
	entry_t            fwd_entry_q;
	entry_t            cur;
	logic              timed;

	always_comb begin
		if (fwd_valid_q && (fwd_slot_q == slot_s1)) begin
			cur = fwd_entry_q;
		end else begin
			cur = rd_entry;
		end
	end

	assign changed = in_range_s1 && (level_s1 != cur.level);
	assign timed   = changed && (level_s1 == LEVEL_HIGH) && (cur.stamp != 32'd0);

	always_comb begin
		wr_entry.level = level_s1;
		priority if (level_s1 == LEVEL_LOW) begin
			wr_entry.stamp = now_s1;
		end else if (timed) begin
			wr_entry.stamp = 32'd0;
		end else begin
			wr_entry.stamp = cur.stamp;
		end
	end

	assign upd.timed   = timed;
	assign upd.elapsed = now_s1 - cur.stamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (commit) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			fwd_slot_q  <= slot_s1;
			fwd_entry_q <= wr_entry;
		end
	end

endmodule

@@ rtl/core/clpt_round.sv @@
// ----------------------------------------------------------------------------
// clpt_round: duration rounding pipeline
// Adds the rounding bias and checks for saturation, divides by one thousand
// through a reciprocal multiply, and holds the result word for the output.
// ----------------------------------------------------------------------------
module clpt_round (
	input  logic           clk,
	input  clpt_pkg::adv_t adv,
	input  clpt_pkg::upd_t upd,
	output logic           duration_valid,
	output logic [7:0]     duration_seconds,
	output logic           duration_saturated
);

	import clpt_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;

	logic              timed_s2;
	logic [31:0]       elapsed_s2;
	logic [32:0]       sum;
	logic              timed_s3;
	logic              sat_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [PROD_W-1:0] prod;
	logic [7:0]        secs;
	logic              valid_s4;
	logic [7:0]        seconds_s4;
	logic              sat_s4;

	assign sum  = {1'b0, elapsed_s2} + 33'(ROUND_BIAS);
	assign prod = PROD_W'(sum_s3) * PROD_W'(RECIP);
	assign secs = prod[RECIP_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			timed_s2   <= upd.timed;
			elapsed_s2 <= upd.elapsed;
		end
		if (adv.s3) begin
			timed_s3 <= timed_s2;
			sat_s3   <= (sum >= 33'(SAT_SUM));
			sum_s3   <= sum[SUM_W-1:0];
		end
		if (adv.s4) begin
			valid_s4   <= timed_s3;
			sat_s4     <= timed_s3 && sat_s3;
			seconds_s4 <= !timed_s3 ? 8'd0 : (sat_s3 ? SECONDS_MAX : secs);
		end
	end

	assign duration_valid     = valid_s4;
	assign duration_seconds   = seconds_s4;
	assign duration_saturated = sat_s4;

endmodule

@@ rtl/core/channel_low_pulse_timer.sv @@
// ----------------------------------------------------------------------------
// channel_low_pulse_timer: low period timer for board voltage channels
// Keeps the last level and low start stamp of every channel in one memory
// and reports the rounded length of each completed low period in seconds.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                   | payload
//  sample   | in        | sample_valid / sample_ready | board, channel, level, now_ms
//  result   | out       | result_valid / result_ready | duration_valid, _seconds, _saturated
//
// One word per cycle while results are taken; each word passes four stages: memory read,
// slot update and write back, bias add and saturation check, reciprocal multiply.
// After reset a clearing pass writes every slot in turn, during which sample_ready stays low.
// A stalled result holds each full stage while empty ones fill; sample_ready drops
// once four words wait. The memory is written when a level change leaves the update stage.
module channel_low_pulse_timer #(
	parameter int BOARDS   = 4,
	parameter int CHANNELS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [1:0]  board,
	input  logic [3:0]  channel,
	input  logic [7:0]  level,
	input  logic [31:0] now_ms,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        duration_valid,
	output logic [7:0]  duration_seconds,
	output logic        duration_saturated
);

	import clpt_pkg::*;

	localparam int SLOTS   = BOARDS * CHANNELS;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENTRY_W = $bits(entry_t);

	logic              clr_busy_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic [SLOT_W-1:0] slot_s1;
	logic              in_range_s1;
	logic [7:0]        level_s1;
	logic [31:0]       now_s1;
	logic              take1;
	logic              take2;
	logic              take3;
	logic              take4;
	logic              fire;
	logic              in_range;
	logic [SLOT_W-1:0] slot;
	logic              changed;
	logic              item_we;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	entry_t            reset_entry;
	entry_t            wr_entry;
	logic [ENTRY_W-1:0] rd_raw;
	upd_t              upd;
	adv_t              adv;

	assign take4 = !valid_s4 || result_ready;
	assign take3 = !valid_s3 || take4;
	assign take2 = !valid_s2 || take3;
	assign take1 = !valid_s1 || take2;

	assign sample_ready = take1 && !clr_busy_q;
	assign fire         = sample_valid && sample_ready;

	assign in_range = (32'(board) < BOARDS) && (32'(channel) < CHANNELS);
	assign slot     = SLOT_W'(32'(board) * CHANNELS + 32'(channel));

	assign item_we = valid_s1 && take2 && changed;

	assign reset_entry.level = LEVEL_RESET;
	assign reset_entry.stamp = 32'd0;

	assign ram_we    = clr_busy_q || item_we;
	assign ram_waddr = clr_busy_q ? clr_cnt_q : slot_s1;
	assign ram_wdata = clr_busy_q ? reset_entry : wr_entry;

	assign adv.s2 = take2;
	assign adv.s3 = take3;
	assign adv.s4 = take4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			if (clr_cnt_q == SLOT_W'(SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (take1) begin
				valid_s1 <= fire;
			end
			if (take2) begin
				valid_s2 <= valid_s1;
			end
			if (take3) begin
				valid_s3 <= valid_s2;
			end
			if (take4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			slot_s1     <= slot;
			in_range_s1 <= in_range;
			level_s1    <= level;
			now_s1      <= now_ms;
		end
	end

	clpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS),
		.AW    (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (fire),
		.raddr (slot),
		.rdata (rd_raw)
	);

	clpt_slot #(
		.SLOT_W (SLOT_W)
	) u_slot (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_entry    (entry_t'(rd_raw)),
		.slot_s1     (slot_s1),
		.in_range_s1 (in_range_s1),
		.level_s1    (level_s1),
		.now_s1      (now_s1),
		.commit      (item_we),
		.changed     (changed),
		.wr_entry    (wr_entry),
		.upd         (upd)
	);

	clpt_round u_round (
		.clk                (clk),
		.adv                (adv),
		.upd                (upd),
		.duration_valid     (duration_valid),
		.duration_seconds   (duration_seconds),
		.duration_saturated (duration_saturated)
	);

	assign result_valid = valid_s4;

	a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !item_we && !valid_s1)
		else $error("slot write or sample in flight during the clearing pass");

	a_sat_gives_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && duration_saturated |-> duration_valid && (duration_seconds == SECONDS_MAX))
		else $error("saturated duration without the maximum value");

	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !duration_valid |-> (duration_seconds == 8'd0) && !duration_saturated)
		else $error("result word without a duration carries nonzero fields");

	a_write_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_we |-> in_range_s1)
		else $error("slot write for a sample outside the board and channel range");

endmodule

@@ tb/sv/channel_low_pulse_timer_tb.sv @@
// ----------------------------------------------------------------------------
// channel_low_pulse_timer_tb: self-checking testbench of the low pulse timer
// A driver feeds sample words from a queue and keeps its own copy of the
// per-channel level and start stamp, so it can work out the duration word that
// each accepted sample should produce. A monitor checks every result word in
// order. Both sides pause at random, and for one long stretch the result side
// holds off completely.
// ----------------------------------------------------------------------------
module channel_low_pulse_timer_tb;

	import clpt_pkg::*;

	localparam int BOARDS   = 4;
	localparam int CHANNELS = 12;
	localparam int SLOTS    = BOARDS * CHANNELS;
	localparam int QUIET    = 150;

	typedef struct {
		logic [1:0]  board;
		logic [3:0]  channel;
		logic [7:0]  level;
		logic [31:0] now_ms;
	} sample_t;

	typedef struct {
		logic       valid;
		logic [7:0] seconds;
		logic       saturated;
	} duration_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [1:0]  board = '0;
	logic [3:0]  channel = '0;
	logic [7:0]  level = '0;
	logic [31:0] now_ms = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        duration_valid;
	logic [7:0]  duration_seconds;
	logic        duration_saturated;
	logic        hold_off = 1'b0;

	sample_t   pending_q[$];
	duration_t duration_q[$];
	sample_t   cur_sample;
	logic [7:0]  model_level[SLOTS];
	logic [31:0] model_stamp[SLOTS];
	logic [7:0]  stim_level[SLOTS];
	logic [31:0] stim_fall[SLOTS];
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int send_gap = 0;
	int recv_gap = 0;

	channel_low_pulse_timer #(
		.BOARDS(BOARDS),
		.CHANNELS(CHANNELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.board(board),
		.channel(channel),
		.level(level),
		.now_ms(now_ms),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.duration_valid(duration_valid),
		.duration_seconds(duration_seconds),
		.duration_saturated(duration_saturated)
	);

	always #5 clk = ~clk;

	function automatic duration_t time_low_period(sample_t s);
		duration_t   r;
		int          slot;
		logic [31:0] elapsed;
		logic [63:0] secs;
		r = '{1'b0, 8'd0, 1'b0};
		if (s.board >= BOARDS || s.channel >= CHANNELS)
			return r;
		slot = s.board * CHANNELS + s.channel;
		if (s.level == model_level[slot])
			return r;
		model_level[slot] = s.level;
		if (s.level == LEVEL_LOW) begin
			model_stamp[slot] = s.now_ms;
		end else if (s.level == LEVEL_HIGH && model_stamp[slot] != 32'd0) begin
			elapsed = s.now_ms - model_stamp[slot];
			secs = (64'(elapsed) + ROUND_BIAS) / MS_PER_SECOND;
			r.valid = 1'b1;
			if (secs > 64'(SECONDS_MAX)) begin
				r.seconds = SECONDS_MAX;
				r.saturated = 1'b1;
			end else begin
				r.seconds = secs[7:0];
			end
			model_stamp[slot] = 32'd0;
		end
		return r;
	endfunction

	task automatic add_sample(logic [1:0] b, logic [3:0] c, logic [7:0] l, logic [31:0] t);
		pending_q.push_back('{b, c, l, t});
		n_queued++;
	endtask

	function automatic logic calm_phase(int n);
		return ((n / 128) % 3) == 1;
	endfunction

	// Driver: one word per acceptance, random gaps between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) begin
				duration_q.push_back(time_low_period(cur_sample));
				n_accepted++;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_sample = pending_q.pop_front();
					board <= cur_sample.board;
					channel <= cur_sample.channel;
					level <= cur_sample.level;
					now_ms <= cur_sample.now_ms;
					sample_valid <= 1'b1;
					if (n_accepted < n_queued - QUIET && !calm_phase(n_accepted) &&
							$urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks result words in order and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		duration_t exp_d;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				n_checked++;
				if (duration_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result word: valid %0b seconds %0d sat %0b",
							duration_valid, duration_seconds, duration_saturated);
				end else begin
					exp_d = duration_q.pop_front();
					if (duration_valid !== exp_d.valid || duration_seconds !== exp_d.seconds ||
							duration_saturated !== exp_d.saturated) begin
						n_errors++;
						if (n_errors <= 10)
							$display("word %0d: expected %0b/%0d/%0b, got %0b/%0d/%0b",
								n_checked, exp_d.valid, exp_d.seconds, exp_d.saturated,
								duration_valid, duration_seconds, duration_saturated);
					end
				end
			end
			if (hold_off) begin
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (n_checked < n_queued - QUIET && !calm_phase(n_checked + 64) &&
						$urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 8);
			end
		end
	end

	// The result side holds off long enough for the pipeline to fill and stall.
	initial begin
		wait (n_accepted >= 400);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#3000000;
		$display("channel_low_pulse_timer: mismatch");
		$finish;
	end

	initial begin
		int          n_real;
		int          slot;
		logic [1:0]  b;
		logic [3:0]  c;
		logic [7:0]  l;
		logic [31:0] t;
		logic [31:0] d;
		for (int i = 0; i < SLOTS; i++) begin
			model_level[i] = LEVEL_RESET;
			model_stamp[i] = 32'd0;
			stim_level[i] = LEVEL_RESET;
			stim_fall[i] = 32'd0;
		end

		// Directed part.
		add_sample(2'd0, 4'd0, LEVEL_RESET, 32'd5);
		add_sample(2'd0, 4'd0, LEVEL_HIGH, 32'd10);
		add_sample(2'd0, 4'd0, LEVEL_LOW, 32'd0);
		add_sample(2'd0, 4'd0, LEVEL_HIGH, 32'd5000);
		add_sample(2'd0, 4'd1, LEVEL_LOW, 32'd1000);
		add_sample(2'd0, 4'd1, LEVEL_HIGH, 32'd1299);
		add_sample(2'd0, 4'd2, LEVEL_LOW, 32'd1000);
		add_sample(2'd0, 4'd2, LEVEL_HIGH, 32'd1300);
		add_sample(2'd1, 4'd0, LEVEL_LOW, 32'hFFFF_FF00);
		add_sample(2'd1, 4'd0, LEVEL_HIGH, 32'h0000_0400);
		add_sample(2'd1, 4'd1, LEVEL_LOW, 32'd1);
		add_sample(2'd1, 4'd1, LEVEL_HIGH, 32'hFFFF_FFFF);
		add_sample(2'd1, 4'd2, LEVEL_LOW, 32'd100);
		add_sample(2'd1, 4'd2, LEVEL_HIGH, 32'd100 + 32'd254799);
		add_sample(2'd1, 4'd3, LEVEL_LOW, 32'd100);
		add_sample(2'd1, 4'd3, LEVEL_HIGH, 32'd100 + 32'd255799);
		add_sample(2'd2, 4'd0, LEVEL_LOW, 32'd7);
		add_sample(2'd2, 4'd0, LEVEL_HIGH, 32'd7 + 32'd255800);
		add_sample(2'd3, 4'd11, LEVEL_LOW, 32'd42);
		add_sample(2'd3, 4'd11, LEVEL_LOW, 32'd9000);
		add_sample(2'd3, 4'd11, 8'h80, 32'd10000);
		add_sample(2'd3, 4'd11, LEVEL_HIGH, 32'd50042);
		add_sample(2'd3, 4'd12, LEVEL_LOW, 32'd1);
		add_sample(2'd2, 4'd15, LEVEL_HIGH, 32'd1);

		// Random part: mostly falls and rises on valid channels.
		n_real = 0;
		while (n_real < 1700) begin
			if ($urandom_range(0, 9) == 0) begin
				b = 2'($urandom);
				c = 4'($urandom_range(CHANNELS, 15));
				add_sample(b, c, 8'($urandom), $urandom);
			end else begin
				b = 2'($urandom_range(0, BOARDS - 1));
				c = 4'($urandom_range(0, CHANNELS - 1));
				slot = b * CHANNELS + c;
				case ($urandom_range(0, 19))
					0, 1, 2: l = 8'($urandom);
					3, 4:    l = stim_level[slot];
					default: l = (stim_level[slot] == LEVEL_LOW) ? LEVEL_HIGH : LEVEL_LOW;
				endcase
				if (l == LEVEL_LOW) begin
					case ($urandom_range(0, 15))
						0:       t = 32'd0;
						1:       t = 32'hFFFF_FFFF - $urandom_range(0, 5000);
						default: t = $urandom;
					endcase
					stim_fall[slot] = t;
				end else if (l == LEVEL_HIGH) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: d = $urandom_range(0, 20000);
						5, 6:          d = $urandom_range(0, 300000);
						7:             d = ($urandom_range(0, 1) ? 32'd254800 : 32'd255800)
								- $urandom_range(0, 1);
						8:             d = $urandom;
						default:       d = $urandom_range(0, 999);
					endcase
					t = stim_fall[slot] + d;
				end else begin
					t = $urandom;
				end
				stim_level[slot] = l;
				add_sample(b, c, l, t);
			end
			n_real++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_checked >= n_queued);
		repeat (20) @(posedge clk);
		if (duration_q.size() != 0 || n_checked != n_queued)
			n_errors++;
		if (n_errors == 0)
			$display("channel_low_pulse_timer: match");
		else
			$display("channel_low_pulse_timer: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/clpt_pkg.sv
rtl/core/clpt_ram.sv
rtl/core/clpt_slot.sv
rtl/core/clpt_round.sv
rtl/core/channel_low_pulse_timer.sv
tb/sv/channel_low_pulse_timer_tb.sv
